/* hw/rtl/rcm_pkg.sv */
// Shared types, sizes, register indexes and the cosine table of the soft mask.
package rcm_pkg;

  // Volume size; each dimension is a power of two.
  localparam int unsigned X_SIZE = 256;
  localparam int unsigned Y_SIZE = 256;
  localparam int unsigned Z_SIZE = 256;

  localparam int unsigned CX = (X_SIZE > 1) ? $clog2(X_SIZE) : 1;
  localparam int unsigned CY = (Y_SIZE > 1) ? $clog2(Y_SIZE) : 1;
  localparam int unsigned CZ = (Z_SIZE > 1) ? $clog2(Z_SIZE) : 1;
  localparam longint unsigned TOTAL = longint'(X_SIZE) * Y_SIZE * Z_SIZE;

  // Axis width: enough for a coordinate and an 8 bit origin, plus sign.
  localparam int unsigned AXB0 = (CX > CY) ? CX : CY;
  localparam int unsigned AXB1 = (AXB0 > CZ) ? AXB0 : CZ;
  localparam int unsigned AXB  = (AXB1 > 8) ? AXB1 : 8;
  localparam int unsigned DW   = AXB + 1;
  localparam int unsigned D2W  = 2 * DW + 1;
  localparam int unsigned NW0  = D2W + 12;
  localparam int unsigned NW   = NW0 + (NW0 % 2);
  localparam int unsigned RB   = NW / 2;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [2:0] REG_INNER      = 3'd3;
  localparam logic [2:0] REG_OUTER      = 3'd4;
  localparam logic [2:0] REG_EDGE_WIDTH = 3'd5;
  localparam logic [2:0] REG_BACKGROUND = 3'd6;

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_BG,
    CLS_BLEND
  } cls_e;

  // One pipeline stage worth of payload.
  typedef struct packed {
    logic [23:0]        idx;
    logic signed [31:0] val;
    logic               inr;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
    logic [NW-1:0]      sn;
    logic [RB+1:0]      srem;
    logic [RB-1:0]      root;
    cls_e               cls;
    logic [31:0]        dd;
    logic [15:0]        drem;
    logic [16:0]        q;
    logic [16:0]        p;
    logic [16:0]        ta;
    logic [15:0]        diff;
    logic [10:0]        frac;
    logic [26:0]        prod;
    logic [16:0]        w;
    logic signed [49:0] m1;
    logic signed [49:0] m2;
  } stage_t;

  // Raised cosine weight over half a turn, Q1.16, 33 points.
  function automatic logic [16:0] cos_tab(input logic [5:0] i);
    logic [16:0] r;
    unique case (i)
      6'd0:  r = 17'd65536;  6'd1:  r = 17'd65378;  6'd2:  r = 17'd64906;
      6'd3:  r = 17'd64125;  6'd4:  r = 17'd63042;  6'd5:  r = 17'd61667;
      6'd6:  r = 17'd60014;  6'd7:  r = 17'd58098;  6'd8:  r = 17'd55938;
      6'd9:  r = 17'd53556;  6'd10: r = 17'd50973;  6'd11: r = 17'd48215;
      6'd12: r = 17'd45308;  6'd13: r = 17'd42280;  6'd14: r = 17'd39161;
      6'd15: r = 17'd35980;  6'd16: r = 17'd32768;  6'd17: r = 17'd29556;
      6'd18: r = 17'd26375;  6'd19: r = 17'd23256;  6'd20: r = 17'd20228;
      6'd21: r = 17'd17321;  6'd22: r = 17'd14563;  6'd23: r = 17'd11980;
      6'd24: r = 17'd9598;   6'd25: r = 17'd7438;   6'd26: r = 17'd5522;
      6'd27: r = 17'd3869;   6'd28: r = 17'd2494;   6'd29: r = 17'd1411;
      6'd30: r = 17'd630;    6'd31: r = 17'd158;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/rcm_in_if.sv */
// Input channel: one voxel word.
interface rcm_in_if;
  logic               valid;
  logic               ready;
  logic [23:0]        voxel_index;
  logic signed [31:0] voxel_value;
  modport source (output valid, voxel_index, voxel_value, input ready);
  modport sink   (input valid, voxel_index, voxel_value, output ready);
endinterface

/* hw/rtl/rcm_out_if.sv */
// Output channel: one masked voxel word.
interface rcm_out_if;
  logic               valid;
  logic               ready;
  logic [23:0]        out_index;
  logic signed [31:0] out_value;
  modport source (output valid, out_index, out_value, input ready);
  modport sink   (input valid, out_index, out_value, output ready);
endinterface

/* hw/rtl/raised_cosine_soft_mask_apply_top.sv */
// Top level of the raised cosine spherical soft mask pipeline.
//
// Voxel words enter on in_ch (index and Q16.16 value) and leave on out_ch
// in the same order, one result per voxel, with valid/ready handshakes.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write them only while idle, and the block itself leaves this unchecked.
// The pipeline has 3 + RB + 38 register stages (57 with the default
// 256 cube). One word enters every cycle while the receiver does not
// stall: the square root takes one result bit per stage and the phase
// divider one quotient bit per stage, both fully unrolled into stages.
// When the receiver stalls with a word waiting at the output, the
// whole pipeline holds and in_ch.ready drops; nothing is lost or repeated.
// Reset clears every stage valid bit and loads the register defaults.
module raised_cosine_soft_mask_apply_top import rcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  rcm_in_if.sink      in_ch,
  rcm_out_if.source   out_ch
);

  localparam int unsigned ST_SQ0 = 3;
  localparam int unsigned ST_CLS = ST_SQ0 + RB;
  localparam int unsigned ST_DV0 = ST_CLS + 1;
  localparam int unsigned ST_LUT = ST_DV0 + 32;
  localparam int unsigned ST_MUL = ST_LUT + 1;
  localparam int unsigned ST_W   = ST_LUT + 2;
  localparam int unsigned ST_BL  = ST_LUT + 3;
  localparam int unsigned ST_OUT = ST_LUT + 4;
  localparam int unsigned NST    = ST_OUT + 1;

  // Configuration registers.
  logic [7:0]         org_x_q, org_y_q, org_z_q;
  logic [15:0]        inner_q, outer_q, ew_q;
  logic signed [31:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= 8'd128;
      org_y_q <= 8'd128;
      org_z_q <= 8'd128;
      inner_q <= 16'd0;
      outer_q <= 16'd0;
      ew_q    <= 16'd64;
      bg_q    <= 32'sd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X:   org_x_q <= cfg_data_i[7:0];
        REG_ORIGIN_Y:   org_y_q <= cfg_data_i[7:0];
        REG_ORIGIN_Z:   org_z_q <= cfg_data_i[7:0];
        REG_INNER:      inner_q <= cfg_data_i[15:0];
        REG_OUTER:      outer_q <= cfg_data_i[15:0];
        REG_EDGE_WIDTH: ew_q    <= cfg_data_i[15:0];
        REG_BACKGROUND: bg_q    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Pipeline registers and the shared advance enable.
  stage_t           pipe_q [NST];
  stage_t           pipe_d [NST];
  logic [NST-1:0]   vld_q;
  logic             en;

  assign en          = !vld_q[NST-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NST; k++) pipe_q[k] <= pipe_d[k];
    end
  end

  logic [15:0] wd;
  assign wd = (ew_q == 16'd0) ? 16'd1 : ew_q;

  // Per stage next-value logic.
  for (genvar k = 0; k < NST; k++) begin : g_st
    if (k == 0) begin : g_in
      always_comb begin
        pipe_d[k]     = '0;
        pipe_d[k].idx = in_ch.voxel_index;
        pipe_d[k].val = in_ch.voxel_value;
        pipe_d[k].inr = 64'(in_ch.voxel_index) < TOTAL;
      end
    end else if (k == 1) begin : g_axis
      logic [31:0] ix;
      assign ix = 32'(pipe_q[k-1].idx);
      // Split the index and subtract the origin.
      always_comb begin
        pipe_d[k]    = pipe_q[k-1];
        pipe_d[k].dx = $signed(DW'(ix[CX-1:0])) - $signed(DW'(org_x_q));
        pipe_d[k].dy = $signed(DW'(ix[CX +: CY])) - $signed(DW'(org_y_q));
        pipe_d[k].dz = $signed(DW'(ix[CX+CY +: CZ])) - $signed(DW'(org_z_q));
      end
    end else if (k == 2) begin : g_sq
      logic signed [2*DW-1:0] sx, sy, sz;
      logic [D2W-1:0]         d2;
      assign sx = pipe_q[k-1].dx * pipe_q[k-1].dx;
      assign sy = pipe_q[k-1].dy * pipe_q[k-1].dy;
      assign sz = pipe_q[k-1].dz * pipe_q[k-1].dz;
      assign d2 = D2W'($unsigned(sx)) + D2W'($unsigned(sy)) + D2W'($unsigned(sz));
      // Squared distance, scaled by 64 squared, seeds the root.
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].sn   = NW'({d2, 12'b0});
        pipe_d[k].srem = '0;
        pipe_d[k].root = '0;
      end
    end else if (k < ST_CLS) begin : g_root
      logic [RB+1:0] rn, tr;
      assign rn = {pipe_q[k-1].srem[RB-1:0], pipe_q[k-1].sn[NW-1 -: 2]};
      assign tr = {pipe_q[k-1].root, 2'b01};
      // One root bit per stage.
      always_comb begin
        pipe_d[k]    = pipe_q[k-1];
        pipe_d[k].sn = pipe_q[k-1].sn << 2;
        if (rn >= tr) begin
          pipe_d[k].srem = rn - tr;
          pipe_d[k].root = {pipe_q[k-1].root[RB-2:0], 1'b1};
        end else begin
          pipe_d[k].srem = rn;
          pipe_d[k].root = {pipe_q[k-1].root[RB-2:0], 1'b0};
        end
      end
    end else if (k == ST_CLS) begin : g_cls
      logic [31:0] r32;
      assign r32 = 32'(pipe_q[k-1].root);
      // Pass inside the inner radius or for an index beyond the volume, background beyond the outer one.
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].drem = '0;
        pipe_d[k].q    = '0;
        pipe_d[k].dd   = {16'(32'(outer_q) - r32), 16'b0};
        if (!pipe_q[k-1].inr || r32 < 32'(inner_q)) begin
          pipe_d[k].cls = CLS_PASS;
        end else if (r32 > 32'(outer_q)) begin
          pipe_d[k].cls = CLS_BG;
        end else begin
          pipe_d[k].cls = CLS_BLEND;
        end
      end
    end else if (k < ST_LUT) begin : g_div
      logic [16:0] rn;
      assign rn = {pipe_q[k-1].drem, pipe_q[k-1].dd[31]};
      // One quotient bit per stage; only the low 17 bits are kept.
      always_comb begin
        pipe_d[k]    = pipe_q[k-1];
        pipe_d[k].dd = pipe_q[k-1].dd << 1;
        if (rn >= {1'b0, wd}) begin
          pipe_d[k].drem = 16'(rn - {1'b0, wd});
          pipe_d[k].q    = {pipe_q[k-1].q[15:0], 1'b1};
        end else begin
          pipe_d[k].drem = rn[15:0];
          pipe_d[k].q    = {pipe_q[k-1].q[15:0], 1'b0};
        end
      end
    end else if (k == ST_LUT) begin : g_lut
      logic [16:0] pm;
      logic [5:0]  ti;
      assign pm = (pipe_q[k-1].q > 17'd65536) ? 17'(18'd131072 - 18'(pipe_q[k-1].q))
                                               : pipe_q[k-1].q;
      assign ti = pm[16:11];
      // Mirror the phase into half a turn and read both table points.
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].p    = pm;
        pipe_d[k].frac = pm[10:0];
        if (ti >= 6'd32) begin
          pipe_d[k].ta   = '0;
          pipe_d[k].diff = '0;
        end else begin
          pipe_d[k].ta   = cos_tab(ti);
          pipe_d[k].diff = 16'(cos_tab(ti) - cos_tab(ti + 6'd1));
        end
      end
    end else if (k == ST_MUL) begin : g_mul
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].prod = 27'(pipe_q[k-1].diff) * 27'(pipe_q[k-1].frac);
      end
    end else if (k == ST_W) begin : g_w
      always_comb begin
        pipe_d[k]   = pipe_q[k-1];
        pipe_d[k].w = pipe_q[k-1].ta - 17'(pipe_q[k-1].prod[26:11]);
      end
    end else if (k == ST_BL) begin : g_bl
      logic signed [17:0] wv, wb;
      assign wb = $signed({1'b0, pipe_q[k-1].w});
      assign wv = $signed(18'(18'd65536 - 18'(pipe_q[k-1].w)));
      // Both blend products.
      always_comb begin
        pipe_d[k]    = pipe_q[k-1];
        pipe_d[k].m1 = pipe_q[k-1].val * wv;
        pipe_d[k].m2 = bg_q * wb;
      end
    end else begin : g_out
      logic signed [50:0] t;
      logic signed [34:0] qv;
      logic signed [31:0] sat;
      assign t  = 51'(pipe_q[k-1].m1) + 51'(pipe_q[k-1].m2) + 51'sd32768;
      assign qv = 35'(t >>> 16);
      assign sat = (qv > 35'sd2147483647) ? 32'sh7fffffff :
                   (qv < -35'sd2147483648) ? 32'sh80000000 : 32'(qv);
      // Round, saturate and pick the result by class.
      always_comb begin
        pipe_d[k] = pipe_q[k-1];
        unique case (pipe_q[k-1].cls)
          CLS_BG:    pipe_d[k].val = bg_q;
          CLS_BLEND: pipe_d[k].val = sat;
          default:   pipe_d[k].val = pipe_q[k-1].val;
        endcase
      end
    end
  end

  assign out_ch.valid     = vld_q[NST-1];
  assign out_ch.out_index = pipe_q[NST-1].idx;
  assign out_ch.out_value = pipe_q[NST-1].val;

  // A stall freezes the whole pipeline.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // The mirrored phase stays within half a turn.
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_LUT] |-> pipe_q[ST_LUT].p <= 17'd65536)
    else $error("phase out of range");

  // The interpolated weight never exceeds one.
  a_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_W] && pipe_q[ST_W].cls == CLS_BLEND |-> pipe_q[ST_W].w <= 17'd65536)
    else $error("weight above one");

endmodule
